FILE: rtl/core/lncp_pkg.sv
// ----------------------------------------------------------------------------
// lncp_pkg
// Shared types, reset values and helpers for the near-plane clip and
// projection pipeline.
// ----------------------------------------------------------------------------
package lncp_pkg;

    // Default number of fraction bits of the camera-space coordinates
    localparam int FRAC_BITS_DEF = 16;

    // Width of a projected screen coordinate before saturation
    localparam int PROJ_PW = 19;

    // Register reset values
    localparam logic [30:0] NEAR_Z_RST        = 31'd655;
    localparam logic [30:0] FOCAL_SCALE_RST   = 31'd16777216;
    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_NEAR_Z        = 2'd0,
        CFG_FOCAL_SCALE   = 2'd1,
        CFG_SCREEN_WIDTH  = 2'd2,
        CFG_SCREEN_HEIGHT = 2'd3
    } cfg_idx_t;

    // Segment as it travels through the clip stages
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [30:0] z1p;
        logic        [30:0] z2p;
        logic        [23:0] color;
        logic               drawn;
        logic               clip_s;
        logic               clip_e;
    } item_t;

    // Clamp to the signed 16-bit screen range
    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767)
        begin
            r = 16'sd32767;
        end
        else if (v < -24'sd32768)
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lncp_proj_lane.sv
// ----------------------------------------------------------------------------
// lncp_proj_lane
// One projection lane: coordinate times focal scale, divided by depth with a
// pipelined restoring divider, then offset by the screen center and truncated.
// ----------------------------------------------------------------------------
module lncp_proj_lane #(
    parameter int FRAC_BITS = lncp_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic signed [31:0]                 coord,
    input  logic        [30:0]                 depth,
    input  logic        [30:0]                 focal,
    input  logic        [11:0]                 center,
    output logic signed [lncp_pkg::PROJ_PW-1:0] p
);

    localparam int FB = FRAC_BITS;
    localparam int QB = FB + 17;
    localparam int SW = QB + 2;
    localparam int PW = lncp_pkg::PROJ_PW;
    localparam logic signed [SW-1:0] RND = SW'((64'd1 << FB) - 64'd1);

    // Multiply
    logic signed [63:0] prod_reg;
    logic        [30:0] zm_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= coord * $signed({1'b0, focal});
        zm_reg   <= depth;
    end

    // Split into sign and magnitude
    logic        [61:0] mag_reg;
    logic               sgn_reg;
    logic        [30:0] zs_reg;
    logic        [63:0] neg_prod;

    assign neg_prod = ~prod_reg + 64'd1;

    always_ff @(posedge clk)
    begin
        sgn_reg <= prod_reg[63];
        mag_reg <= prod_reg[63] ? neg_prod[61:0] : prod_reg[61:0];
        zs_reg  <= zm_reg;
    end

    // Divider: detect quotient overflow, then one quotient bit per stage
    logic [30:0]   drem_reg [0:QB];
    logic [QB-1:0] dlow_reg [0:QB];
    logic [QB-1:0] dq_reg   [0:QB];
    logic [30:0]   dz_reg   [0:QB];
    logic          dneg_reg [0:QB];
    logic          dovf_reg [0:QB];
    logic [61:0]   hi;

    assign hi = mag_reg >> QB;

    always_ff @(posedge clk)
    begin
        drem_reg[0] <= hi[30:0];
        dlow_reg[0] <= mag_reg[QB-1:0];
        dq_reg[0]   <= '0;
        dz_reg[0]   <= zs_reg;
        dneg_reg[0] <= sgn_reg;
        dovf_reg[0] <= (hi >= 62'(zs_reg));
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_div
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;

        assign trial = {drem_reg[k-1], dlow_reg[k-1][QB-1]};
        assign ge    = trial >= {1'b0, dz_reg[k-1]};
        assign diff  = trial - {1'b0, dz_reg[k-1]};

        always_ff @(posedge clk)
        begin
            drem_reg[k] <= ge ? diff[30:0] : trial[30:0];
            dlow_reg[k] <= {dlow_reg[k-1][QB-2:0], 1'b0};
            dq_reg[k]   <= {dq_reg[k-1][QB-2:0], ge};
            dz_reg[k]   <= dz_reg[k-1];
            dneg_reg[k] <= dneg_reg[k-1];
            dovf_reg[k] <= dovf_reg[k-1];
        end
    end

    // Clamp, apply sign and add the center
    logic        [QB:0]   qm;
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] cen;
    logic signed [SW-1:0] s_reg;

    assign qm  = dovf_reg[QB] ? ((QB+1)'(1) << QB) : {1'b0, dq_reg[QB]};
    assign qs  = $signed({1'b0, qm});
    assign cen = $signed({{(SW-12-FB){1'b0}}, center, {FB{1'b0}}});

    always_ff @(posedge clk)
    begin
        s_reg <= dneg_reg[QB] ? (cen - qs) : (cen + qs);
    end

    // Truncate toward zero
    logic signed [SW-1:0] sb;
    logic signed [PW-1:0] p_reg;

    assign sb = s_reg + (s_reg[SW-1] ? RND : '0);

    always_ff @(posedge clk)
    begin
        p_reg <= sb[SW-1:FB];
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/line_near_clip_project.sv
// ----------------------------------------------------------------------------
// line_near_clip_project
// Clips a camera-space line segment against the near plane and projects
// both ends to saturated screen coordinates.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     start / busy         start_x..end_z, line_color
//  result    done (strobe)        drawn, start_px..end_py, out_color
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One segment enters every cycle; busy stays low. Each result passes the
//  clip-parameter divider (FRAC_BITS+1 stages) and the depth divider in the
//  projection lanes (FRAC_BITS+17 stages). Results come as a one-cycle done
//  strobe; the receiver cannot stall, so nothing in the pipe ever holds.
//  Reset clears the valid chain and loads the register reset values.
// ----------------------------------------------------------------------------
module line_near_clip_project #(
    parameter int FRAC_BITS = lncp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic        [23:0] line_color,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [31:0] cfg_data,
    output logic               done,
    output logic               drawn,
    output logic signed [15:0] start_px,
    output logic signed [15:0] start_py,
    output logic signed [15:0] end_px,
    output logic signed [15:0] end_py,
    output logic        [23:0] out_color
);

    localparam int FB       = FRAC_BITS;
    localparam int TB       = FB + 1;            // clip parameter bits, t <= ONE
    localparam int QB       = FB + 17;           // projection quotient bits
    localparam int PROJ_LAT = QB + 5;            // projection lane depth
    localparam int LAT      = TB + 5 + PROJ_LAT; // start to done
    localparam int PRW      = 33 + TB + 1;       // lerp product width
    localparam int LQW      = PRW - FB;          // lerp step width
    localparam int PW       = lncp_pkg::PROJ_PW;
    localparam logic signed [PRW-1:0] RND = PRW'((64'd1 << FB) - 64'd1);

    // The pipe never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [30:0] near_z_reg;
    logic [30:0] focal_scale_reg;
    logic [12:0] screen_width_reg;
    logic [12:0] screen_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_z_reg        <= lncp_pkg::NEAR_Z_RST;
            focal_scale_reg   <= lncp_pkg::FOCAL_SCALE_RST;
            screen_width_reg  <= lncp_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= lncp_pkg::SCREEN_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (lncp_pkg::cfg_idx_t'(cfg_index))
                lncp_pkg::CFG_NEAR_Z:        near_z_reg        <= cfg_data[30:0];
                lncp_pkg::CFG_FOCAL_SCALE:   focal_scale_reg   <= cfg_data[30:0];
                lncp_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[12:0];
                lncp_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[12:0];
            endcase
        end
    end

    // A zero near plane acts as one LSB so the depth divisor of a drawn segment is never zero
    logic [30:0] nz_eff;
    assign nz_eff = (near_z_reg == '0) ? 31'd1 : near_z_reg;

    // ------------------------------------------------------------------------
    // Valid chain: one bit per register stage, start to done
    // ------------------------------------------------------------------------
    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
        end
    end

    assign done = vld_reg[LAT-1];

    // ------------------------------------------------------------------------
    // Entry: classify ends against the near plane, set up the clip divide
    // ------------------------------------------------------------------------
    logic signed [32:0] nz_s;
    logic signed [32:0] z1_s;
    logic signed [32:0] z2_s;
    logic signed [32:0] z_near;
    logic signed [32:0] z_far;
    logic signed [32:0] num_d;
    logic signed [32:0] den_d;
    logic               lt1;
    logic               lt2;
    lncp_pkg::item_t    item_a;

    always_comb
    begin
        nz_s   = $signed({2'b00, nz_eff});
        z1_s   = {start_z[31], start_z};
        z2_s   = {end_z[31], end_z};
        lt1    = z1_s < nz_s;
        lt2    = z2_s < nz_s;

        item_a.x1     = start_x;
        item_a.y1     = start_y;
        item_a.x2     = end_x;
        item_a.y2     = end_y;
        item_a.dx     = {end_x[31], end_x} - {start_x[31], start_x};
        item_a.dy     = {end_y[31], end_y} - {start_y[31], start_y};
        item_a.color  = line_color;
        item_a.drawn  = ~(lt1 & lt2);
        item_a.clip_s = lt1 & ~lt2;
        item_a.clip_e = ~lt1 & lt2;
        // An unclipped visible end has depth >= near, so it fits 31 bits
        item_a.z1p    = item_a.clip_s ? nz_eff : start_z[30:0];
        item_a.z2p    = item_a.clip_e ? nz_eff : end_z[30:0];

        // t runs from the start end toward the other end: depth distance from
        // the start end to the plane, over the segment depth
        z_near = item_a.clip_s ? z1_s : z2_s;
        z_far  = item_a.clip_s ? z2_s : z1_s;
        num_d  = item_a.clip_s ? (nz_s - z1_s) : (z1_s - nz_s);
        den_d  = z_far - z_near;
    end

    // ------------------------------------------------------------------------
    // Clip parameter t = num * ONE / den, one quotient bit per stage.
    // t never exceeds ONE, so TB bits cover it and the first partial
    // remainder is num / 2.
    // ------------------------------------------------------------------------
    lncp_pkg::item_t titem_reg [0:TB];
    logic [31:0]     trem_reg  [0:TB];
    logic [TB-1:0]   tlow_reg  [0:TB];
    logic [TB-1:0]   tq_reg    [0:TB];
    logic [31:0]     tden_reg  [0:TB];

    always_ff @(posedge clk)
    begin
        titem_reg[0] <= item_a;
        trem_reg[0]  <= num_d[32:1];
        tlow_reg[0]  <= {num_d[0], {FB{1'b0}}};
        tq_reg[0]    <= '0;
        tden_reg[0]  <= den_d[31:0];
    end

    for (genvar k = 1; k <= TB; k++)
    begin : g_tdiv
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        assign trial = {trem_reg[k-1], tlow_reg[k-1][TB-1]};
        assign ge    = trial >= {1'b0, tden_reg[k-1]};
        assign diff  = trial - {1'b0, tden_reg[k-1]};

        always_ff @(posedge clk)
        begin
            titem_reg[k] <= titem_reg[k-1];
            trem_reg[k]  <= ge ? diff[31:0] : trial[31:0];
            tlow_reg[k]  <= {tlow_reg[k-1][TB-2:0], 1'b0};
            tq_reg[k]    <= {tq_reg[k-1][TB-2:0], ge};
            tden_reg[k]  <= tden_reg[k-1];
        end
    end

    // ------------------------------------------------------------------------
    // Interpolate the clipped end: x1 + (x2 - x1) * t / ONE
    // ------------------------------------------------------------------------
    logic signed [PRW-1:0] lmx_next;
    logic signed [PRW-1:0] lmy_next;
    logic signed [PRW-1:0] lmx_reg;
    logic signed [PRW-1:0] lmy_reg;
    lncp_pkg::item_t       litem1_reg;

    assign lmx_next = titem_reg[TB].dx * $signed({1'b0, tq_reg[TB]});
    assign lmy_next = titem_reg[TB].dy * $signed({1'b0, tq_reg[TB]});

    always_ff @(posedge clk)
    begin
        lmx_reg    <= lmx_next;
        lmy_reg    <= lmy_next;
        litem1_reg <= titem_reg[TB];
    end

    // Divide by ONE toward zero
    logic signed [PRW-1:0] lbx;
    logic signed [PRW-1:0] lby;
    logic signed [LQW-1:0] lqx_reg;
    logic signed [LQW-1:0] lqy_reg;
    lncp_pkg::item_t       litem2_reg;

    assign lbx = lmx_reg + (lmx_reg[PRW-1] ? RND : '0);
    assign lby = lmy_reg + (lmy_reg[PRW-1] ? RND : '0);

    always_ff @(posedge clk)
    begin
        lqx_reg    <= lbx[PRW-1:FB];
        lqy_reg    <= lby[PRW-1:FB];
        litem2_reg <= litem1_reg;
    end

    // Add the base end and drop the result in place of the clipped end
    logic signed [LQW-1:0] nx;
    logic signed [LQW-1:0] ny;
    logic signed [31:0]    cx1_reg;
    logic signed [31:0]    cy1_reg;
    logic signed [31:0]    cx2_reg;
    logic signed [31:0]    cy2_reg;
    logic        [30:0]    cz1_reg;
    logic        [30:0]    cz2_reg;
    logic                  cdrawn_reg;
    logic        [23:0]    ccolor_reg;

    assign nx = LQW'(litem2_reg.x1) + lqx_reg;
    assign ny = LQW'(litem2_reg.y1) + lqy_reg;

    always_ff @(posedge clk)
    begin
        cx1_reg    <= litem2_reg.clip_s ? nx[31:0] : litem2_reg.x1;
        cy1_reg    <= litem2_reg.clip_s ? ny[31:0] : litem2_reg.y1;
        cx2_reg    <= litem2_reg.clip_e ? nx[31:0] : litem2_reg.x2;
        cy2_reg    <= litem2_reg.clip_e ? ny[31:0] : litem2_reg.y2;
        cz1_reg    <= litem2_reg.z1p;
        cz2_reg    <= litem2_reg.z2p;
        cdrawn_reg <= litem2_reg.drawn;
        ccolor_reg <= litem2_reg.color;
    end

    // ------------------------------------------------------------------------
    // Projection: four lanes, one per screen coordinate
    // ------------------------------------------------------------------------
    logic signed [PW-1:0] p_x1;
    logic signed [PW-1:0] p_y1;
    logic signed [PW-1:0] p_x2;
    logic signed [PW-1:0] p_y2;

    lncp_proj_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x1 (
        .clk    (clk),
        .coord  (cx1_reg),
        .depth  (cz1_reg),
        .focal  (focal_scale_reg),
        .center (screen_width_reg[12:1]),
        .p      (p_x1)
    );

    lncp_proj_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y1 (
        .clk    (clk),
        .coord  (cy1_reg),
        .depth  (cz1_reg),
        .focal  (focal_scale_reg),
        .center (screen_height_reg[12:1]),
        .p      (p_y1)
    );

    lncp_proj_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x2 (
        .clk    (clk),
        .coord  (cx2_reg),
        .depth  (cz2_reg),
        .focal  (focal_scale_reg),
        .center (screen_width_reg[12:1]),
        .p      (p_x2)
    );

    lncp_proj_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y2 (
        .clk    (clk),
        .coord  (cy2_reg),
        .depth  (cz2_reg),
        .focal  (focal_scale_reg),
        .center (screen_height_reg[12:1]),
        .p      (p_y2)
    );

    // Carry drawn flag and color alongside the lanes
    logic        sb_drawn_reg [0:PROJ_LAT-1];
    logic [23:0] sb_color_reg [0:PROJ_LAT-1];

    always_ff @(posedge clk)
    begin
        sb_drawn_reg[0] <= cdrawn_reg;
        sb_color_reg[0] <= ccolor_reg;
    end

    for (genvar k = 1; k < PROJ_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            sb_drawn_reg[k] <= sb_drawn_reg[k-1];
            sb_color_reg[k] <= sb_color_reg[k-1];
        end
    end

    // ------------------------------------------------------------------------
    // Output: flip rows, saturate, zero the coordinates of a rejected segment
    // ------------------------------------------------------------------------
    logic signed [23:0] hm1;
    logic signed [23:0] fy1;
    logic signed [23:0] fy2;
    logic               vis;
    logic               drawn_reg;
    logic signed [15:0] start_px_reg;
    logic signed [15:0] start_py_reg;
    logic signed [15:0] end_px_reg;
    logic signed [15:0] end_py_reg;
    logic        [23:0] out_color_reg;

    assign hm1 = $signed({11'd0, screen_height_reg}) - 24'sd1;
    assign fy1 = hm1 - {{(24-PW){p_y1[PW-1]}}, p_y1};
    assign fy2 = hm1 - {{(24-PW){p_y2[PW-1]}}, p_y2};
    assign vis = sb_drawn_reg[PROJ_LAT-1];

    always_ff @(posedge clk)
    begin
        drawn_reg     <= vis;
        out_color_reg <= sb_color_reg[PROJ_LAT-1];
        start_px_reg  <= vis ? lncp_pkg::sat16({{(24-PW){p_x1[PW-1]}}, p_x1}) : '0;
        start_py_reg  <= vis ? lncp_pkg::sat16(fy1) : '0;
        end_px_reg    <= vis ? lncp_pkg::sat16({{(24-PW){p_x2[PW-1]}}, p_x2}) : '0;
        end_py_reg    <= vis ? lncp_pkg::sat16(fy2) : '0;
    end

    assign drawn     = drawn_reg;
    assign start_px  = start_px_reg;
    assign start_py  = start_py_reg;
    assign end_px    = end_px_reg;
    assign end_py    = end_py_reg;
    assign out_color = out_color_reg;

`ifndef SYNTHESIS
    // Every accepted item produces a done strobe at the end of the valid chain
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("item did not complete after the pipeline latency");

    // No result without a matching accepted item
    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching item");

    // A rejected segment leaves all screen coordinates at zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !drawn |-> start_px == 16'sd0 && start_py == 16'sd0 &&
                           end_px == 16'sd0 && end_py == 16'sd0)
        else $error("rejected segment carries screen coordinates");
`endif

endmodule
